### rtl/bta_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the batched two-choice allocator.
// No dependencies; used by the top level and its checker.
package bta_pkg;

    localparam int BIN_COUNT_DEF = 1024;
    localparam int LOAD_BITS_DEF = 32;

    localparam int SAMPLE_W = 10;
    localparam int WEIGHT_W = 16;
    localparam int SUM_W    = 48;
    localparam int OUT_W    = 32;
    localparam int IDX_W    = 17;   // holds any bin count up to 65536

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 80;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE     = 2'd0;
    localparam logic [1:0] CFG_CHOICES  = 2'd1;
    localparam logic [1:0] CFG_QLIMIT   = 2'd2;
    localparam logic [1:0] CFG_BATCH    = 2'd3;

    // selection rules
    localparam logic [2:0] MODE_DMAX    = 3'd0;
    localparam logic [2:0] MODE_TWO     = 3'd1;
    localparam logic [2:0] MODE_BETA_LT = 3'd2;
    localparam logic [2:0] MODE_QUANT   = 3'd3;
    localparam logic [2:0] MODE_BETA_MX = 3'd4;

    localparam logic [2:0]  MODE_RST    = MODE_TWO;
    localparam logic [1:0]  CHOICES_RST = 2'd2;
    localparam logic [10:0] QLIMIT_RST  = 11'd512;
    localparam logic [19:0] BATCH_RST   = 20'd1024;

endpackage

### rtl/batched_two_choice_allocator.sv
`timescale 1ns / 1ps
// Batched two-choice ball allocator: top level.
// Depends on bta_pkg.
//
// Input stream s_axis: one ball per transaction (three bin samples, weight in
// tdata, coin in tuser). Output stream m_axis: one result per ball (chosen bin,
// max load, gap in tdata; tlast marks the ball that closed a batch).
// Configuration: i_cfg_valid/o_cfg_ready write channel, register index in
// i_cfg_index, value in i_cfg_data; write only while the block is idle.
// A ball goes through the LOOK, SEL, UPD and WAIT states before its result is
// registered: two load-table reads, a batch buffer read-modify-write and the
// average kept as quotient and remainder by a reciprocal multiply.
// The ball that closes a batch also runs a merge pass over all BIN_COUNT entries
// and a merge sort of ceil(log2(BIN_COUNT)) passes, both through the single load
// memory write port.
// One ball is in work at a time; the next is taken as soon as the result is in
// the output register, and a stalled receiver holds that register and the
// block until the result is taken.
// After reset a clearing pass over all BIN_COUNT entries zeroes the loads and the
// batch buffer; input is held off until it ends.
module batched_two_choice_allocator #(
    parameter int BIN_COUNT = bta_pkg::BIN_COUNT_DEF,
    parameter int LOAD_BITS = bta_pkg::LOAD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sample_a[9:0], sample_b[19:10], sample_c[29:20], weight[45:30]
    input  logic [bta_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // use_second[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // chosen_bin[9:0], max_load[41:10], gap[73:42]
    output logic [bta_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    localparam int BW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int AW = BW + 1;
    localparam int CW = BW + 2;
    localparam int SW = bta_pkg::SUM_W;
    localparam int IW = bta_pkg::IDX_W;
    localparam int RK = IW + BW;
    localparam logic [SW-1:0] SUM_MAX = {SW{1'b1}};
    localparam logic [SW-1:0] Q_SAT = SW'(SUM_MAX / BIN_COUNT);
    localparam logic [IW:0]   R_SAT = (IW+1)'(SUM_MAX % BIN_COUNT);
    localparam logic [IW:0]   NB    = (IW+1)'(BIN_COUNT);
    localparam logic [CW-1:0] NBC   = CW'(BIN_COUNT);
    localparam logic [19:0]   RECIP = 20'(((64'd1 << RK) + 64'(BIN_COUNT) - 64'd1)
                                          / 64'(BIN_COUNT));

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LOOK = 4'd1;
    localparam logic [3:0] ST_SEL  = 4'd2;
    localparam logic [3:0] ST_UPD  = 4'd3;
    localparam logic [3:0] ST_WAIT = 4'd4;
    localparam logic [3:0] ST_MRD  = 4'd5;
    localparam logic [3:0] ST_MWR  = 4'd6;
    localparam logic [3:0] ST_SINI = 4'd7;
    localparam logic [3:0] ST_SRD  = 4'd8;
    localparam logic [3:0] ST_SWR  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;
    localparam logic [3:0] ST_CLR  = 4'd11;

    logic [LOAD_BITS-1:0] mem_ld [0:(2**AW)-1];
    logic [LOAD_BITS-1:0] mem_bf [0:(2**BW)-1];

    logic [3:0]  r_state;
    logic [2:0]  r_mode;
    logic [1:0]  r_choices;
    logic [10:0] r_qlim;
    logic [19:0] r_batch;
    logic [19:0] r_count;

    logic [IW-1:0] r_sa, r_sb, r_sc, r_bin;
    logic        r_coin;
    logic [15:0] r_w;
    logic        r_closed;
    logic        r_bank;

    logic [LOAD_BITS-1:0] r_ld_a, r_ld_b, r_bf_q, r_largest;
    logic [SW-1:0] r_sum, r_q;
    logic [IW:0]   r_r;

    logic [IW:0]   r_dv_x, r_dv_r;
    logic [IW-1:0] r_dv_q;

    logic [CW-1:0] r_i, r_j, r_k, r_lo, r_mid, r_hi, r_wd;

    logic        r_m_valid, r_m_last;
    logic [bta_pkg::M_TDATA_W-1:0] r_m_data;

    // combinational
    logic [AW-1:0] ld_ra, ld_rb, ld_wa;
    logic [LOAD_BITS-1:0] ld_wd, bf_wd;
    logic          ld_we, bf_we;
    logic [BW-1:0] bf_ra, bf_wa;
    logic [IW-1:0] sel_bin, lighter, dmax;
    logic [LOAD_BITS:0] sum_ext;
    logic [LOAD_BITS:0] bsum_ext;
    logic [37:0]   dv_prod;
    logic [IW-1:0] dv_q;
    logic [IW:0]   dv_rem;
    logic         take_i;
    logic [CW-1:0] lo_next, wd_next;
    logic [SW:0]   sum_next;
    logic [19:0]   cnt_next, limit;
    logic          closes;
    logic [SW-1:0] lg_ext, gap_w;
    logic [bta_pkg::OUT_W-1:0] mx_o, gap_o;
    logic          out_free;

    function automatic logic [IW-1:0] clamp_bin(input logic [bta_pkg::SAMPLE_W-1:0] s);
        logic [IW-1:0] v;
        v = IW'(s);
        clamp_bin = (v >= IW'(BIN_COUNT)) ? IW'(BIN_COUNT - 1) : v;
    endfunction

    function automatic logic [bta_pkg::OUT_W-1:0] sat32(input logic [SW-1:0] v);
        sat32 = (v > SW'({bta_pkg::OUT_W{1'b1}})) ? {bta_pkg::OUT_W{1'b1}}
                                                   : v[bta_pkg::OUT_W-1:0];
    endfunction

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;
    assign out_free      = !r_m_valid || m_axis_tready;

    // bin selection
    always_comb begin
        logic [1:0] d;
        d       = (r_choices == 2'd0) ? 2'd1 : r_choices;
        lighter = (r_ld_a <= r_ld_b) ? r_sa : r_sb;
        dmax    = r_sa;
        if (d >= 2'd2 && r_sb > dmax) begin
            dmax = r_sb;
        end
        if (d == 2'd3 && r_sc > dmax) begin
            dmax = r_sc;
        end
        case (r_mode)
            bta_pkg::MODE_DMAX:    sel_bin = dmax;
            bta_pkg::MODE_BETA_LT: sel_bin = r_coin ? lighter : r_sa;
            bta_pkg::MODE_QUANT:   sel_bin = (r_coin && r_sa < IW'(r_qlim)) ? r_sb : r_sa;
            bta_pkg::MODE_BETA_MX: sel_bin = (r_coin && r_sa < r_sb) ? r_sb : r_sa;
            default:               sel_bin = lighter;
        endcase
    end

    // remainder plus weight split by the bin count: reciprocal multiply, then remainder
    always_comb begin
        dv_prod = 38'(r_dv_x) * 38'(RECIP);
        dv_q    = IW'(dv_prod >> RK);
        dv_rem  = r_dv_x - (IW+1)'((IW+1)'(r_dv_q) * NB);
    end

    always_comb begin
        sum_ext  = {1'b0, r_bf_q} + {1'b0, LOAD_BITS'(r_w)};
        bsum_ext = {1'b0, r_ld_a} + {1'b0, r_bf_q};
        sum_next = {1'b0, r_sum} + (SW+1)'(r_w);
        limit    = (r_batch == 20'd0) ? 20'd1 : r_batch;
        cnt_next = r_count + 20'd1;
        closes   = (cnt_next >= limit) || (cnt_next == 20'd0);
        take_i   = (r_i < r_mid) && ((r_j >= r_hi) || (r_ld_a >= r_ld_b));
        lo_next  = r_lo + (r_wd << 1);
        wd_next  = r_wd << 1;
        lg_ext   = SW'(r_largest);
        gap_w    = (lg_ext > r_q) ? (lg_ext - r_q) : '0;
        mx_o     = sat32(lg_ext);
        gap_o    = sat32(gap_w);
    end

    // memory port steering
    always_comb begin
        ld_ra = {r_bank, r_sa[BW-1:0]};
        ld_rb = {r_bank, r_sb[BW-1:0]};
        ld_we = 1'b0;
        ld_wa = {r_bank, r_i[BW-1:0]};
        ld_wd = bsum_ext[LOAD_BITS] ? {LOAD_BITS{1'b1}} : bsum_ext[LOAD_BITS-1:0];
        bf_ra = sel_bin[BW-1:0];
        bf_we = 1'b0;
        bf_wa = r_bin[BW-1:0];
        bf_wd = sum_ext[LOAD_BITS] ? {LOAD_BITS{1'b1}} : sum_ext[LOAD_BITS-1:0];
        case (r_state)
            ST_CLR: begin
                ld_we = 1'b1;
                ld_wd = '0;
                bf_we = 1'b1;
                bf_wa = r_i[BW-1:0];
                bf_wd = '0;
            end
            ST_UPD: begin
                bf_we = 1'b1;
            end
            ST_MRD: begin
                ld_ra = {r_bank, r_i[BW-1:0]};
                bf_ra = r_i[BW-1:0];
            end
            ST_MWR: begin
                ld_we = 1'b1;
                bf_we = 1'b1;
                bf_wa = r_i[BW-1:0];
                bf_wd = '0;
            end
            ST_SRD: begin
                ld_ra = {r_bank, r_i[BW-1:0]};
                ld_rb = {r_bank, r_j[BW-1:0]};
            end
            ST_SWR: begin
                ld_we = 1'b1;
                ld_wa = {~r_bank, r_k[BW-1:0]};
                ld_wd = take_i ? r_ld_a : r_ld_b;
            end
            default: begin
                ld_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ld_a <= mem_ld[ld_ra];
        r_ld_b <= mem_ld[ld_rb];
        if (ld_we) begin
            mem_ld[ld_wa] <= ld_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bf_q <= mem_bf[bf_ra];
        if (bf_we) begin
            mem_bf[bf_wa] <= bf_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= bta_pkg::MODE_RST;
            r_choices <= bta_pkg::CHOICES_RST;
            r_qlim    <= bta_pkg::QLIMIT_RST;
            r_batch   <= bta_pkg::BATCH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bta_pkg::CFG_MODE:    r_mode    <= i_cfg_data[2:0];
                bta_pkg::CFG_CHOICES: r_choices <= i_cfg_data[1:0];
                bta_pkg::CFG_QLIMIT:  r_qlim    <= i_cfg_data[10:0];
                bta_pkg::CFG_BATCH:   r_batch   <= i_cfg_data;
                default:              r_mode    <= r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_axis_tvalid) begin
            r_sa     <= clamp_bin(s_axis_tdata[9:0]);
            r_sb     <= clamp_bin(s_axis_tdata[19:10]);
            r_sc     <= clamp_bin(s_axis_tdata[29:20]);
            r_w      <= s_axis_tdata[45:30];
            r_coin   <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_i       <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_q       <= '0;
            r_r       <= '0;
            r_largest <= '0;
            r_bank    <= 1'b0;
            r_closed  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_state == ST_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_CLR: begin
                    if (r_i == NBC - CW'(1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_i     <= r_i + CW'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    r_dv_x  <= r_r + (IW+1)'(r_w);
                    r_state <= ST_SEL;
                end
                ST_SEL: begin
                    r_bin   <= sel_bin;
                    r_dv_q  <= dv_q;
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_dv_r  <= dv_rem;
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (sum_next > (SW+1)'(SUM_MAX)) begin
                        r_sum <= SUM_MAX;
                        r_q   <= Q_SAT;
                        r_r   <= R_SAT;
                    end else begin
                        r_sum <= sum_next[SW-1:0];
                        r_q   <= r_q + SW'(r_dv_q);
                        r_r   <= r_dv_r;
                    end
                    r_closed <= closes;
                    r_count  <= closes ? 20'd0 : cnt_next;
                    r_i      <= '0;
                    r_state  <= closes ? ST_MRD : ST_OUT;
                end
                ST_MRD: begin
                    r_state <= ST_MWR;
                end
                ST_MWR: begin
                    if (ld_wd > r_largest) begin
                        r_largest <= ld_wd;
                    end
                    if (r_i == NBC - CW'(1)) begin
                        r_lo    <= '0;
                        r_wd    <= CW'(1);
                        r_state <= ST_SINI;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= ST_MRD;
                    end
                end
                ST_SINI: begin
                    r_i     <= r_lo;
                    r_k     <= r_lo;
                    r_mid   <= (r_lo + r_wd > NBC) ? NBC : r_lo + r_wd;
                    r_j     <= (r_lo + r_wd > NBC) ? NBC : r_lo + r_wd;
                    r_hi    <= (lo_next > NBC) ? NBC : lo_next;
                    r_state <= ST_SRD;
                end
                ST_SRD: begin
                    r_state <= ST_SWR;
                end
                ST_SWR: begin
                    if (take_i) begin
                        r_i <= r_i + CW'(1);
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                    if (r_k + CW'(1) == r_hi) begin
                        if (lo_next >= NBC) begin
                            r_bank <= ~r_bank;
                            r_wd   <= wd_next;
                            r_lo   <= '0;
                            r_state <= (wd_next >= NBC) ? ST_OUT : ST_SINI;
                        end else begin
                            r_lo    <= lo_next;
                            r_state <= ST_SINI;
                        end
                    end else begin
                        r_k     <= r_k + CW'(1);
                        r_state <= ST_SRD;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_m_last  <= r_closed;
                        r_m_data  <= {6'd0, gap_o, mx_o, r_bin[9:0]};
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/bta_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the batched two-choice allocator, bound to the top.
// Depends on bta_pkg for the output stream width.
module bta_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tlast,
    input logic [bta_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_one_ball: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second ball taken while one is in work");

    a_gap_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[73:42] <= m_axis_tdata[41:10])
        else $error("gap above max load");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind batched_two_choice_allocator bta_checker u_bta_checker (.*);
